@@ sv/mwf_pkg.sv @@
// Shared types and constants for the streaming median window filter.
// No dependencies; used by median_window_filter through scoped names.
package mwf_pkg;

	localparam int KERNEL_SIZE = 3;
	localparam int MAX_WIDTH   = 1024;

	localparam int WIN_AREA   = KERNEL_SIZE * KERNEL_SIZE;
	localparam int MID_RANK   = WIN_AREA / 2;
	localparam int HEIGHT_CAP = 4096;

	localparam int PIX_W        = 8;
	localparam int ROW_W        = 12;
	localparam int CCOL_W       = 10;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int CPOS_W       = (COL_W > CCOL_W) ? COL_W : CCOL_W;
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_ADDR_W   = 1;
	// compare widths for the column and row position against the frame size
	localparam int WCMP_W = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
	localparam int HCMP_W = (ROW_W + 1 > CFG_HEIGHT_W) ? ROW_W + 1 : CFG_HEIGHT_W;
	// one line store word holds the KERNEL_SIZE-1 pixels above a column
	localparam int LS_W = (KERNEL_SIZE - 1) * PIX_W;

	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = CFG_WIDTH_W'(1024);
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = CFG_HEIGHT_W'(768);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_IMAGE_WIDTH  = CFG_ADDR_W'(0),
		REG_IMAGE_HEIGHT = CFG_ADDR_W'(1)
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0]  median_value;
		logic [ROW_W-1:0]  centre_row;
		logic [CCOL_W-1:0] centre_col;
	} res_t;

endpackage

@@ sv/median_window_filter.sv @@
// Streaming KERNEL_SIZE x KERNEL_SIZE median filter, top level.
// Depends on mwf_pkg (types, sizes, register indexes).
//
// Grey pixels arrive in raster order on the pix channel, one transaction
// per pixel, and may be taken at one per clock. For every pixel that
// completes a window lying wholly inside the image, one transaction on the
// res channel carries the window median and the row and column of the
// window centre; border pixels give nothing. A taken pixel is registered
// in stage 1 and its result then in the output register, later only while
// the output register still holds an earlier result. The K-1 pixels above
// each column come from a line store of MAX_WIDTH words with one write and
// one read port, read on acceptance; the write back happens as the pixel
// leaves stage 1, with a bypass for the case where the next pixel reads
// the same column. The median is a combinational rank selection over the
// window. While a result waits in the output register one further pixel
// is held in stage 1, and pixels that give no result keep flowing. After
// reset all MAX_WIDTH (1024 here) line store words are swept to zero, one
// word per clock; pix_ready stays low during that sweep, configuration
// writes are taken throughout. Image size is clamped to [KERNEL_SIZE,
// MAX_WIDTH] by [KERNEL_SIZE, 4096]; frame_start returns the position to
// row 0, column 0, and the position wraps by itself after a frame's last pixel.
module median_window_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [mwf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [mwf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// pixel input
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  mwf_pkg::pix_t                   pix_data,
	// median results
	output logic                            res_valid,
	input  logic                            res_ready,
	output mwf_pkg::res_t                   res_data
);

	localparam int K      = mwf_pkg::KERNEL_SIZE;
	localparam int PIX_W  = mwf_pkg::PIX_W;
	localparam int COL_W  = mwf_pkg::COL_W;
	localparam int ROW_W  = mwf_pkg::ROW_W;
	localparam int WCMP_W = mwf_pkg::WCMP_W;
	localparam int HCMP_W = mwf_pkg::HCMP_W;
	localparam int CPOS_W = mwf_pkg::CPOS_W;
	localparam int LS_W   = mwf_pkg::LS_W;
	localparam int N      = mwf_pkg::WIN_AREA;

	// ------------------------------------------------------------------
	// Configuration registers and clamped frame size
	// ------------------------------------------------------------------
	logic [mwf_pkg::CFG_WIDTH_W-1:0]  width_q;
	logic [mwf_pkg::CFG_HEIGHT_W-1:0] height_q;
	logic [WCMP_W-1:0]                eff_w;
	logic [HCMP_W-1:0]                eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mwf_pkg::WIDTH_RST;
			height_q <= mwf_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				mwf_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata[mwf_pkg::CFG_WIDTH_W-1:0];
				mwf_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata[mwf_pkg::CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_w = WCMP_W'(width_q);
		if (eff_w < WCMP_W'(K))
			eff_w = WCMP_W'(K);
		if (eff_w > WCMP_W'(mwf_pkg::MAX_WIDTH))
			eff_w = WCMP_W'(mwf_pkg::MAX_WIDTH);
		eff_h = HCMP_W'(height_q);
		if (eff_h < HCMP_W'(K))
			eff_h = HCMP_W'(K);
		if (eff_h > HCMP_W'(mwf_pkg::HEIGHT_CAP))
			eff_h = HCMP_W'(mwf_pkg::HEIGHT_CAP);
	end

	// ------------------------------------------------------------------
	// Line store clearing sweep after reset
	// ------------------------------------------------------------------
	logic [COL_W:0] clr_cnt_q;
	logic           clearing;

	assign clearing = (clr_cnt_q < (COL_W+1)'(mwf_pkg::MAX_WIDTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (clearing)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// ------------------------------------------------------------------
	// Handshake and pipeline flow
	// ------------------------------------------------------------------
	logic v_s1;
	logic emit_s1;
	logic s2_free;
	logic retire;
	logic accept;

	// stage 1 may move on if its result has room, or if it has no result
	assign s2_free   = !res_valid || res_ready;
	assign retire    = v_s1 && (s2_free || !emit_s1);
	assign pix_ready = !clearing && (!v_s1 || retire);
	assign accept    = pix_valid && pix_ready;

	// ------------------------------------------------------------------
	// Raster position of the incoming pixel
	// ------------------------------------------------------------------
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  c0;
	logic [ROW_W-1:0]  r0;
	logic [HCMP_W-1:0] r1;
	logic [COL_W-1:0]  col_a;
	logic [ROW_W-1:0]  row_a;
	logic [WCMP_W-1:0] cn;
	logic [HCMP_W-1:0] rn;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic              emit_a;

	always_comb begin
		c0 = pix_data.frame_start ? '0 : col_q;
		r0 = pix_data.frame_start ? '0 : row_q;
		// catch up on a size that shrank below the stored position
		if (WCMP_W'(c0) >= eff_w) begin
			col_a = '0;
			r1    = HCMP_W'(r0) + 1'b1;
		end else begin
			col_a = c0;
			r1    = HCMP_W'(r0);
		end
		row_a = (r1 >= eff_h) ? '0 : r1[ROW_W-1:0];

		cn = WCMP_W'(col_a) + 1'b1;
		rn = HCMP_W'(row_a) + 1'b1;
		if (cn >= eff_w) begin
			col_n = '0;
			row_n = (rn >= eff_h) ? '0 : rn[ROW_W-1:0];
		end else begin
			col_n = cn[COL_W-1:0];
			row_n = row_a;
		end

		emit_a = (row_a >= ROW_W'(K - 1)) && (col_a >= COL_W'(K - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 registers
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             fwd_s1;
	logic [LS_W-1:0]  fwd_data_s1;
	logic [LS_W-1:0]  rd_q;
	logic [LS_W-1:0]  wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else if (accept) begin
			v_s1    <= 1'b1;
			emit_s1 <= emit_a;
			// same column written back by the retiring pixel: take its data
			fwd_s1  <= retire && (col_s1 == col_a);
		end else if (retire) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pix_data.pixel;
			col_s1      <= col_a;
			row_s1      <= row_a;
			fwd_data_s1 <= wr_data;
		end
	end

	// ------------------------------------------------------------------
	// Line store: lane k holds the pixel K-1-k lines above, oldest first
	// ------------------------------------------------------------------
	logic [LS_W-1:0]  ls_mem [mwf_pkg::MAX_WIDTH];
	logic             mem_we;
	logic [COL_W-1:0] mem_wa;
	logic [LS_W-1:0]  mem_wd;

	assign mem_we = clearing || retire;
	assign mem_wa = clearing ? clr_cnt_q[COL_W-1:0] : col_s1;
	assign mem_wd = clearing ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (mem_we)
			ls_mem[mem_wa] <= mem_wd;
		if (accept)
			rd_q <= ls_mem[col_a];
	end

	// ------------------------------------------------------------------
	// New column, window shift and write-back data
	// ------------------------------------------------------------------
	logic [LS_W-1:0]  above;
	logic [PIX_W-1:0] column [K];
	logic [PIX_W-1:0] win_q  [K][K];
	logic [PIX_W-1:0] win_n  [K][K];

	assign above = fwd_s1 ? fwd_data_s1 : rd_q;

	always_comb begin
		for (int k = 0; k < K - 1; k++)
			column[k] = above[k*PIX_W +: PIX_W];
		column[K-1] = pix_s1;

		for (int k = 0; k < K - 1; k++)
			wr_data[k*PIX_W +: PIX_W] = column[k+1];

		for (int r = 0; r < K; r++) begin
			for (int c = 0; c < K - 1; c++)
				win_n[r][c] = win_q[r][c+1];
			win_n[r][K-1] = column[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < K; r++)
				for (int c = 0; c < K; c++)
					win_q[r][c] <= '0;
		end else if (retire) begin
			win_q <= win_n;
		end
	end

	// ------------------------------------------------------------------
	// Median: rank every element (ties broken by position), pick the middle
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] vals [N];
	logic [N-1:0]     below [N];
	logic [PIX_W-1:0] median;

	always_comb begin
		for (int r = 0; r < K; r++)
			for (int c = 0; c < K; c++)
				vals[r*K + c] = win_n[r][c];

		median = '0;
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++)
				below[i][j] = (vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i));
			if ($countones(below[i]) == mwf_pkg::MID_RANK)
				median = vals[i];
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [CPOS_W-1:0] ccol_full;
	logic [ROW_W-1:0]  crow;

	assign ccol_full = CPOS_W'(col_s1) - CPOS_W'(K - 1) + CPOS_W'(K / 2);
	assign crow      = row_s1 - ROW_W'(K - 1) + ROW_W'(K / 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (retire && emit_s1)
			res_valid <= 1'b1;
		else if (res_ready)
			res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (retire && emit_s1) begin
			res_data.median_value <= median;
			res_data.centre_row   <= crow;
			res_data.centre_col   <= ccol_full[mwf_pkg::CCOL_W-1:0];
		end
	end

endmodule
